@@ src/plist_pkg.sv @@
package plist_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 12;
    localparam int REQ_W        = 3;
    localparam int CAPACITY_DEF = 1024;

    typedef enum logic [REQ_W-1:0] {
        REQ_LEN  = 3'd0,
        REQ_INS  = 3'd1,
        REQ_READ = 3'd2,
        REQ_RM   = 3'd3,
        REQ_MOVE = 3'd4,
        REQ_MAX  = 3'd5
    } t_req;

    typedef struct packed {
        logic              vld;
        logic [DATA_W-1:0] data;
    } t_res;

endpackage

@@ src/plist_ram.sv @@
module plist_ram #(
    parameter int DEPTH = plist_pkg::CAPACITY_DEF,
    parameter int AW    = 10
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [plist_pkg::DATA_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [plist_pkg::DATA_W-1:0] o_rdata
);

    logic [plist_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [plist_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/plist_ctrl.sv @@
module plist_ctrl #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF,
    parameter int AW       = 10,
    parameter int CW       = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [plist_pkg::REQ_W-1:0]  i_req_type,
    input  logic signed [plist_pkg::POS_W-1:0] i_position,
    input  logic signed [plist_pkg::DATA_W-1:0] i_value,
    output logic                         o_ready,
    input  logic                         i_out_free,
    output plist_pkg::t_res              o_res,
    output logic                         o_we,
    output logic [AW-1:0]                o_waddr,
    output logic [plist_pkg::DATA_W-1:0] o_wdata,
    output logic                         o_re,
    output logic [AW-1:0]                o_raddr,
    input  logic [plist_pkg::DATA_W-1:0] i_rdata
);

    localparam int DW   = plist_pkg::DATA_W;
    localparam int CMPW = (CW > plist_pkg::POS_W) ? CW : plist_pkg::POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN,
        S_EMIT
    } t_state;

    t_state            r_state;
    plist_pkg::t_req   r_op;
    logic [AW-1:0]     r_at;
    logic [AW-1:0]     r_ri;
    logic [CW-1:0]     r_left;
    logic              r_pv;
    logic [AW-1:0]     r_pa;
    logic [DW-1:0]     r_held;
    logic [CW-1:0]     r_cnt;
    logic [DW-1:0]     r_res;
    logic [DW-1:0]     r_val;

    plist_pkg::t_req   req;
    logic              pos_neg;
    logic              pos_head;
    logic [CMPW-1:0]   pos_u;
    logic [CMPW-1:0]   cnt_u;
    logic              pos_ge_cnt;
    logic [AW-1:0]     pos_at;
    logic [AW-1:0]     cnt_a;
    logic              full;
    logic [AW-1:0]     at_ins;
    logic [AW-1:0]     at_rm;
    logic              consume;

    assign req        = plist_pkg::t_req'(i_req_type);
    assign pos_neg    = i_position[plist_pkg::POS_W-1];
    assign pos_head   = pos_neg || (i_position == '0);
    assign pos_u      = CMPW'($unsigned(i_position));
    assign cnt_u      = CMPW'(r_cnt);
    assign pos_ge_cnt = !pos_neg && (pos_u >= cnt_u);
    assign pos_at     = pos_u[AW-1:0];
    assign cnt_a      = r_cnt[AW-1:0];
    assign full       = (r_cnt == CW'(CAPACITY));
    assign at_ins     = pos_head ? '0 : (pos_ge_cnt ? cnt_a : pos_at);
    assign at_rm      = pos_head ? '0 : pos_at;
    assign consume    = (r_state == S_WALK) && r_pv;

    assign o_ready    = (r_state == S_IDLE);
    assign o_res.vld  = (r_state == S_EMIT) && i_out_free;
    assign o_res.data = r_res;
    assign o_re       = (r_state == S_WALK) && (r_left != '0);
    assign o_raddr    = r_ri;

    // Shift words one slot per cycle behind the read stream; finish with the new tail/slot.
    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_pa - AW'(1);
        o_wdata = i_rdata;
        if (consume) begin
            case (r_op)
                plist_pkg::REQ_INS: begin
                    o_we    = 1'b1;
                    o_waddr = r_pa + AW'(1);
                end
                plist_pkg::REQ_RM:   o_we = 1'b1;
                plist_pkg::REQ_MOVE: o_we = (r_pa != r_at);
                default:             o_we = 1'b0;
            endcase
        end else if (r_state == S_FIN) begin
            if (r_op == plist_pkg::REQ_INS) begin
                o_we    = 1'b1;
                o_waddr = r_at;
                o_wdata = r_val;
            end else if (r_op == plist_pkg::REQ_MOVE) begin
                o_we    = 1'b1;
                o_waddr = cnt_a - AW'(1);
                o_wdata = r_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_pv <= 1'b0;
                    if (i_valid) begin
                        r_op  <= req;
                        r_val <= i_value;
                        case (req)
                            plist_pkg::REQ_LEN: begin
                                r_res   <= DW'(r_cnt);
                                r_state <= S_EMIT;
                            end
                            plist_pkg::REQ_INS: begin
                                if (!full) begin
                                    r_at    <= at_ins;
                                    r_ri    <= cnt_a - AW'(1);
                                    r_left  <= r_cnt - CW'(at_ins);
                                    r_state <= S_WALK;
                                end
                            end
                            plist_pkg::REQ_READ: begin
                                if (pos_neg || pos_ge_cnt) begin
                                    r_res   <= '1;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_ri    <= pos_at;
                                    r_left  <= CW'(1);
                                    r_state <= S_WALK;
                                end
                            end
                            plist_pkg::REQ_RM: begin
                                if ((r_cnt != '0) && !pos_ge_cnt) begin
                                    r_at    <= at_rm;
                                    r_ri    <= at_rm + AW'(1);
                                    r_left  <= r_cnt - CW'(1) - CW'(at_rm);
                                    r_state <= S_WALK;
                                end
                            end
                            plist_pkg::REQ_MOVE: begin
                                if ((r_cnt > CW'(1)) && !pos_neg && !pos_ge_cnt) begin
                                    r_at    <= pos_at;
                                    r_ri    <= pos_at;
                                    r_left  <= r_cnt - CW'(pos_at);
                                    r_state <= S_WALK;
                                end
                            end
                            plist_pkg::REQ_MAX: begin
                                if (r_cnt == '0) begin
                                    r_res   <= '1;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_ri    <= '0;
                                    r_left  <= r_cnt;
                                    r_state <= S_WALK;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_WALK: begin
                    if (r_pv) begin
                        case (r_op)
                            plist_pkg::REQ_READ: r_held <= i_rdata;
                            plist_pkg::REQ_MAX: begin
                                if ((r_pa == '0) || ($signed(i_rdata) > $signed(r_held))) begin
                                    r_held <= i_rdata;
                                end
                            end
                            plist_pkg::REQ_MOVE: begin
                                if (r_pa == r_at) begin
                                    r_held <= i_rdata;
                                end
                            end
                            default: r_held <= r_held;
                        endcase
                    end
                    if (r_left != '0) begin
                        r_pv   <= 1'b1;
                        r_pa   <= r_ri;
                        r_ri   <= (r_op == plist_pkg::REQ_INS) ? r_ri - AW'(1) : r_ri + AW'(1);
                        r_left <= r_left - CW'(1);
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    case (r_op)
                        plist_pkg::REQ_INS: begin
                            r_cnt   <= r_cnt + CW'(1);
                            r_state <= S_IDLE;
                        end
                        plist_pkg::REQ_RM: begin
                            r_cnt   <= r_cnt - CW'(1);
                            r_state <= S_IDLE;
                        end
                        plist_pkg::REQ_READ, plist_pkg::REQ_MAX: begin
                            r_res   <= r_held;
                            r_state <= S_EMIT;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_EMIT: begin
                    // hold the word until the output register frees up
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_waddr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (CW'(o_waddr) <= r_cnt))
        else $error("write beyond end of list");

    a_walk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) && (r_left != '0) |=> (r_left == $past(r_left) - CW'(1)))
        else $error("walk counter did not advance");

    a_len_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && i_valid && (req == plist_pkg::REQ_LEN)
        |=> (r_state == S_EMIT) && (r_res == DW'($past(r_cnt))))
        else $error("length request not answered");

endmodule

@@ src/positional_list_engine.sv @@
// Ordered list of up to CAPACITY signed 32-bit words in one single-port-write,
// registered-read RAM, run by a sequencer that moves one word per cycle.
// Length and out-of-range reads answer without touching the RAM; a valid read
// reads one word. Insert, remove, move-to-tail and maximum stream over the
// affected words at one RAM access per cycle. The block takes one request at
// a time; o_ready is high only while the sequencer is idle. Results sit in an
// output register, so a new request is taken while the previous result still
// waits for i_ready. Inserts into a full list are dropped.
module positional_list_engine #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [plist_pkg::REQ_W-1:0]         i_req_type,
    input  logic signed [plist_pkg::POS_W-1:0]  i_position,
    input  logic signed [plist_pkg::DATA_W-1:0] i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [plist_pkg::DATA_W-1:0] o_result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    plist_pkg::t_res               res;
    logic                          out_free;
    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [plist_pkg::DATA_W-1:0]  wdata;
    logic                          re;
    logic [AW-1:0]                 raddr;
    logic [plist_pkg::DATA_W-1:0]  rdata;
    logic                          r_ovld;
    logic [plist_pkg::DATA_W-1:0]  r_ores;

    assign out_free = !r_ovld || i_ready;

    plist_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_position (i_position),
        .i_value    (i_value),
        .o_ready    (o_ready),
        .i_out_free (out_free),
        .o_res      (res),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    plist_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (res.vld) begin
            r_ovld <= 1'b1;
            r_ores <= res.data;
        end else if (i_ready) begin
            r_ovld <= 1'b0;
        end
    end

    assign o_valid  = r_ovld;
    assign o_result = r_ores;

endmodule

@@ tb/positional_list_engine_tb.sv @@
`timescale 1ns / 100ps

module positional_list_engine_tb;

    localparam int          DATA_W        = plist_pkg::DATA_W;
    localparam int          POS_W         = plist_pkg::POS_W;
    localparam int          REQ_W         = plist_pkg::REQ_W;
    localparam int          CAPACITY_DEF  = plist_pkg::CAPACITY_DEF;
    localparam int          LIMIT_CYCLES  = 1_000_000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          RANDOM_ITEMS  = 520;
    localparam int          POS_APPEND    = 1024;
    localparam int          POS_LOW       = -1024;
    localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;
    localparam logic signed [DATA_W-1:0] NO_ENTRY = -1;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'h8000_0000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [REQ_W-1:0]         i_req_type;
    logic signed [POS_W-1:0]  i_position;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [DATA_W-1:0] o_result;

    // predicted list contents, head at index 0
    logic signed [DATA_W-1:0] list_words [0:CAPACITY_DEF-1];
    int                       list_len;
    logic signed [DATA_W-1:0] expected_results [$];
    int unsigned              mismatch_count;
    int unsigned              cycle_count;
    bit                       burst_mode;
    bit                       hold_request;

    positional_list_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_position (i_position),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (burst_mode)
            return 0;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        else if (roll < 88)
            return $urandom_range(3, 1);
        else if (roll < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // Apply one accepted request to the list copy; return 1 when it yields a word.
    function automatic bit predict_request(input logic [REQ_W-1:0] kind, input int pos,
                                           input logic signed [DATA_W-1:0] val,
                                           output logic signed [DATA_W-1:0] answer);
        int                       at;
        logic signed [DATA_W-1:0] held;
        answer = '0;
        case (kind)
            plist_pkg::REQ_LEN: begin
                answer = DATA_W'(list_len);
                return 1'b1;
            end
            plist_pkg::REQ_INS: begin
                if (list_len >= CAPACITY_DEF)
                    return 1'b0;
                at = (pos <= 0) ? 0 : ((pos >= list_len) ? list_len : pos);
                for (int k = list_len; k > at; k--)
                    list_words[k] = list_words[k-1];
                list_words[at] = val;
                list_len++;
                return 1'b0;
            end
            plist_pkg::REQ_READ: begin
                answer = (pos < 0 || pos >= list_len) ? NO_ENTRY : list_words[pos];
                return 1'b1;
            end
            plist_pkg::REQ_RM: begin
                if (list_len == 0 || (pos > 0 && pos >= list_len))
                    return 1'b0;
                at = (pos <= 0) ? 0 : pos;
                for (int k = at; k + 1 < list_len; k++)
                    list_words[k] = list_words[k+1];
                list_len--;
                return 1'b0;
            end
            plist_pkg::REQ_MOVE: begin
                if (list_len <= 1 || pos < 0 || pos >= list_len)
                    return 1'b0;
                held = list_words[pos];
                for (int k = pos; k + 1 < list_len; k++)
                    list_words[k] = list_words[k+1];
                list_words[list_len-1] = held;
                return 1'b0;
            end
            plist_pkg::REQ_MAX: begin
                answer = NO_ENTRY;
                if (list_len > 0) begin
                    answer = list_words[0];
                    for (int k = 1; k < list_len; k++)
                        if (list_words[k] > answer)
                            answer = list_words[k];
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Check outgoing words against the oldest prediction, then predict accepted requests.
    always @(posedge i_clk) begin : port_monitor
        logic signed [DATA_W-1:0] answer;
        logic signed [DATA_W-1:0] oldest;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result: expected none, got %0d", o_result);
                    mismatch_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    if (o_result !== oldest) begin
                        $error("result: expected %0d, got %0d", oldest, o_result);
                        mismatch_count++;
                    end
                end
            end
            if (i_valid && o_ready)
                if (predict_request(i_req_type, int'(i_position), i_value, answer))
                    expected_results.push_back(answer);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $error("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        i_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_request(input logic [REQ_W-1:0] kind, input int pos,
                                input logic signed [DATA_W-1:0] val);
        int unsigned idle;
        idle = pick_gap();
        if (idle > 0) begin
            i_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= kind;
        i_position <= POS_W'(pos);
        i_value    <= val;
        do
            @(posedge i_clk);
        while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic test_empty_list();
        send_request(plist_pkg::REQ_LEN, 0, 0);
        send_request(plist_pkg::REQ_READ, 0, 0);
        send_request(plist_pkg::REQ_READ, -1, 0);
        send_request(plist_pkg::REQ_MAX, 0, 0);
        send_request(plist_pkg::REQ_RM, 0, 0);
        send_request(plist_pkg::REQ_MOVE, 0, 0);
        send_request(REQ_RSVD_6, 0, 0);
        send_request(REQ_RSVD_7, -1, -1);
        // single entry: move must leave it alone
        send_request(plist_pkg::REQ_INS, 0, 0);
        send_request(plist_pkg::REQ_MOVE, 0, 0);
        send_request(plist_pkg::REQ_READ, 0, 0);
        send_request(plist_pkg::REQ_RM, 0, 0);
        send_request(plist_pkg::REQ_LEN, 0, 0);
    endtask

    task automatic test_directed_edits();
        send_request(plist_pkg::REQ_INS, 0, WORD_MIN);
        send_request(plist_pkg::REQ_MAX, 0, 0);
        send_request(plist_pkg::REQ_INS, POS_LOW, -1);
        send_request(plist_pkg::REQ_INS, POS_APPEND, WORD_MAX);
        send_request(plist_pkg::REQ_INS, 1, 32'h5555_5555);
        send_request(plist_pkg::REQ_INS, 3, 32'hAAAA_AAAA);
        send_request(plist_pkg::REQ_LEN, 0, 0);
        send_request(plist_pkg::REQ_READ, 0, 0);
        send_request(plist_pkg::REQ_READ, 4, 0);
        send_request(plist_pkg::REQ_READ, 5, 0);
        send_request(plist_pkg::REQ_READ, -1, 0);
        send_request(plist_pkg::REQ_READ, POS_APPEND, 0);
        send_request(plist_pkg::REQ_MAX, 0, 0);
        send_request(plist_pkg::REQ_MOVE, 0, 0);
        send_request(plist_pkg::REQ_MOVE, 4, 0);
        send_request(plist_pkg::REQ_MOVE, -1, 0);
        send_request(plist_pkg::REQ_MOVE, 5, 0);
        send_request(plist_pkg::REQ_RM, 5, 0);
        send_request(plist_pkg::REQ_RM, POS_APPEND, 0);
        send_request(plist_pkg::REQ_RM, POS_LOW, 0);
        send_request(plist_pkg::REQ_RM, 1, 0);
        send_request(plist_pkg::REQ_READ, 1, 0);
        send_request(plist_pkg::REQ_LEN, 0, 0);
        send_request(plist_pkg::REQ_MAX, 0, 0);
    endtask

    // Hold off the receiver while requests keep coming so the block stalls its input.
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        for (int n = 0; n < 12; n++)
            case (n % 3)
                0: send_request(plist_pkg::REQ_LEN, 0, 0);
                1: send_request(plist_pkg::REQ_READ, n % 4, 0);
                default: send_request(plist_pkg::REQ_MAX, 0, 0);
            endcase
    endtask

    function automatic int pick_position();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return $urandom_range(list_len, 0);
        else if (roll < 75)
            return -int'($urandom_range(3, 1));
        else if (roll < 85)
            return list_len - 1 + int'($urandom_range(2));
        return int'($urandom_range(2048)) - 1024;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return $urandom;
        else if (roll < 87)
            return int'($urandom_range(6)) - 3;
        case ($urandom_range(3))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    task automatic test_random_requests(input int unsigned item_total);
        int unsigned roll;
        int unsigned grow_weight;
        int unsigned shrink_weight;
        int          target_len;
        target_len = 0;
        for (int unsigned n = 0; n < item_total; n++) begin
            if (n % 48 == 0)
                burst_mode = ($urandom_range(3) == 0);
            if (n % 64 == 0)
                target_len = ($urandom_range(9) == 0) ? 120 : $urandom_range(48);
            // steer the length toward the current target
            grow_weight   = (list_len < target_len) ? 40 : 12;
            shrink_weight = (list_len > target_len) ? 40 : 12;
            roll = $urandom_range(99);
            if (roll < grow_weight)
                send_request(plist_pkg::REQ_INS, pick_position(), pick_value());
            else if (roll < grow_weight + shrink_weight)
                send_request(plist_pkg::REQ_RM, pick_position(), pick_value());
            else if (roll < 97)
                case ($urandom_range(5))
                    0: send_request(plist_pkg::REQ_LEN, pick_position(), pick_value());
                    1, 2: send_request(plist_pkg::REQ_READ, pick_position(), pick_value());
                    3, 4: send_request(plist_pkg::REQ_MOVE, pick_position(), pick_value());
                    default: send_request(plist_pkg::REQ_MAX, pick_position(), pick_value());
                endcase
            else
                send_request($urandom_range(1) ? REQ_RSVD_6 : REQ_RSVD_7,
                             pick_position(), pick_value());
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_req_type     = plist_pkg::REQ_LEN;
        i_position     = '0;
        i_value        = '0;
        list_len       = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        burst_mode     = 1'b0;
        hold_request   = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_list();
        test_directed_edits();
        test_output_backpressure();
        test_random_requests(RANDOM_ITEMS);

        i_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        // let a trailing list walk finish before the final verdict
        repeat (CAPACITY_DEF + 16) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
src/plist_pkg.sv
src/plist_ram.sv
src/plist_ctrl.sv
src/positional_list_engine.sv
tb/positional_list_engine_tb.sv
